// ===== hdl/fce_pkg.sv =====
// Shared types and constants for the feedback comb echo block.
package fce_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int DLEN_W        = 10;
    localparam int GAIN_W        = 15;
    localparam int PROD_W        = SAMPLE_W + GAIN_W;
    localparam int FRAC_W        = 15;
    localparam int MAX_DELAY_DEF = 512;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [DLEN_W-1:0] DELAY_LEN_RST = 10'd512;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 15'd21845;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [0:0] {
        REG_DELAY_LEN = 1'b0,
        REG_GAIN      = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [DLEN_W-1:0] delay_length;
        logic [GAIN_W-1:0] feedback_gain;
    } t_cfg;

endpackage

// ===== hdl/fce_if.sv =====
// Stream channel interfaces for input and output sample beats.
interface fce_in_if import fce_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       in_block_last;

    modport source(output valid, output sample_in, output in_block_last, input ready);
    modport sink(input valid, input sample_in, input in_block_last, output ready);
endinterface

interface fce_out_if import fce_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       out_block_last;

    modport source(output valid, output sample_out, output out_block_last, input ready);
    modport sink(input valid, input sample_out, input out_block_last, output ready);
endinterface

// ===== hdl/fce_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
module fce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                                       i_clk,
    input  logic                                       i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                           i_wr_data,
    input  logic                                       i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                           o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/fce_cfg.sv =====
// APB register file: delay length and feedback gain.
module fce_cfg import fce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [DLEN_W-1:0] r_delay_len;
    logic [GAIN_W-1:0] r_gain;
    logic              wr_en;
    t_reg_idx          idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[APB_AW-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_len <= DELAY_LEN_RST;
            r_gain      <= GAIN_RST;
        end else if (wr_en) begin
            case (idx)
                REG_DELAY_LEN: begin
                    r_delay_len <= pwdata[DLEN_W-1:0];
                end
                REG_GAIN: begin
                    r_gain <= pwdata[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DELAY_LEN: prdata = {{(APB_DW-DLEN_W){1'b0}}, r_delay_len};
            REG_GAIN:      prdata = {{(APB_DW-GAIN_W){1'b0}}, r_gain};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.delay_length  = r_delay_len;
    assign o_cfg.feedback_gain = r_gain;

endmodule

// ===== hdl/fce_pipe.sv =====
// Delay store read-modify-write pipeline: read, multiply, add/saturate, write back.
module fce_pipe import fce_pkg::*; #(
    parameter int MAX_DELAY = MAX_DELAY_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    fce_in_if.sink    i_smp,
    fce_out_if.source o_smp
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int FW = AW + 1;
    localparam int CW = (FW > DLEN_W) ? FW : DLEN_W;
    localparam int SW = SAMPLE_W + 2;

    // pointer and fill count
    logic [AW-1:0] r_wp, n_wp;
    logic [FW-1:0] r_fill, n_fill;
    logic [CW-1:0] dlen_ext, eff_len, wp_inc;

    // stage 1: RAM data returns
    logic                       r_s1_valid;
    logic [AW-1:0]              r_s1_addr;
    logic signed [SAMPLE_W-1:0] r_s1_x;
    logic                       r_s1_last;
    logic                       r_s1_hit;
    logic                       r_s1_fwd;
    logic [SAMPLE_W-1:0]        r_s1_fwd_data;

    // stage 2: product held
    logic                       r_s2_valid;
    logic [AW-1:0]              r_s2_addr;
    logic signed [SAMPLE_W-1:0] r_s2_x;
    logic                       r_s2_last;
    logic signed [PROD_W-1:0]   r_s2_prod;

    // output register
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_last;

    logic                       out_adv, s2_free, s2_adv, s1_free, hazard, accept;
    logic                       wr_en;
    logic [SAMPLE_W-1:0]        rd_data;
    logic signed [SAMPLE_W-1:0] delayed;
    logic signed [2*SAMPLE_W-1:0] prod_full;
    logic signed [SAMPLE_W-1:0] scaled_floor;
    logic                       round_in;
    logic signed [SW-1:0]       sum;
    logic signed [SAMPLE_W-1:0] sum_sat;

    // handshake and hazard control
    assign out_adv = !r_out_valid || o_smp.ready;
    assign s2_adv  = r_s2_valid && out_adv;
    assign s2_free = !r_s2_valid || out_adv;
    assign s1_free = !r_s1_valid || s2_free;
    assign hazard  = (r_s1_valid && (r_s1_addr == r_wp))
                  || (r_s2_valid && (r_s2_addr == r_wp) && !s2_adv);
    assign i_smp.ready = s1_free && !hazard;
    assign accept      = i_smp.valid && i_smp.ready;
    assign wr_en       = s2_adv;

    // pointer wrap against the effective delay length
    always_comb begin
        dlen_ext = CW'(i_cfg.delay_length);
        if (dlen_ext == '0) begin
            eff_len = CW'(1);
        end else if (dlen_ext > CW'(MAX_DELAY)) begin
            eff_len = CW'(MAX_DELAY);
        end else begin
            eff_len = dlen_ext;
        end
        wp_inc = CW'(r_wp) + CW'(1);
        n_wp   = (wp_inc >= eff_len) ? '0 : r_wp + AW'(1);
    end

    always_comb begin
        n_fill = r_fill;
        if (wr_en && (FW'(r_s2_addr) == r_fill)) begin
            n_fill = r_fill + FW'(1);
        end
    end

    fce_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s2_addr),
        .i_wr_data (sum_sat),
        .i_rd_en   (accept),
        .i_rd_addr (r_wp),
        .o_rd_data (rd_data)
    );

    // stage 1 math: select delayed sample, multiply by gain
    always_comb begin
        if (r_s1_fwd) begin
            delayed = r_s1_fwd_data;
        end else if (r_s1_hit) begin
            delayed = rd_data;
        end else begin
            delayed = '0;
        end
        prod_full = delayed * $signed({1'b0, i_cfg.feedback_gain});
    end

    // stage 2 math: truncate toward zero, add, saturate
    always_comb begin
        scaled_floor = r_s2_prod[PROD_W-1:FRAC_W];
        round_in     = r_s2_prod[PROD_W-1] && (r_s2_prod[FRAC_W-1:0] != '0);
        sum = SW'(r_s2_x) + SW'(scaled_floor) + SW'({1'b0, round_in});
        if (sum > SW'(SAMPLE_MAX)) begin
            sum_sat = SAMPLE_MAX;
        end else if (sum < SW'(SAMPLE_MIN)) begin
            sum_sat = SAMPLE_MIN;
        end else begin
            sum_sat = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (accept) begin
                r_wp <= n_wp;
            end
            if (s1_free) begin
                r_s1_valid <= accept;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr     <= r_wp;
            r_s1_x        <= i_smp.sample_in;
            r_s1_last     <= i_smp.in_block_last;
            r_s1_hit      <= (FW'(r_wp) < r_fill);
            r_s1_fwd      <= wr_en && (r_s2_addr == r_wp);
            r_s1_fwd_data <= sum_sat;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_addr <= r_s1_addr;
            r_s2_x    <= r_s1_x;
            r_s2_last <= r_s1_last;
            r_s2_prod <= prod_full[PROD_W-1:0];
        end
        if (s2_adv) begin
            r_out_sample <= sum_sat;
            r_out_last   <= r_s2_last;
        end
    end

    assign o_smp.valid          = r_out_valid;
    assign o_smp.sample_out     = r_out_sample;
    assign o_smp.out_block_last = r_out_last;

    a_no_same_entry_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_s1_valid && r_s2_valid && (r_s1_addr == r_s2_addr)))
        else $error("two in-flight beats target the same delay entry");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAX_DELAY))
        else $error("fill count beyond store depth");

    a_fill_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_fill >= $past(r_fill)))
        else $error("fill count went backward");

endmodule

// ===== hdl/feedback_comb_echo_core.sv =====
// Top level of the feedback comb echo: register file and delay store pipeline.
//
//  channel   dir   handshake          payload
//  i_smp     in    valid/ready        sample_in[15:0] signed, in_block_last
//  o_smp     out   valid/ready        sample_out[15:0] signed, out_block_last
//  apb       in    psel/penable/pready delay_length @0x0, feedback_gain @0x4
//
// One beat per cycle while o_smp.ready is high and the effective delay length
// exceeds one; beats pass stage 1, stage 2 and the output register. At length
// one, each beat waits for the prior write-back through multiply and saturate.
// Reset clears control state only; a fill count marks unwritten entries as zero.
// The output register holds while o_smp.ready is low; input keeps flowing until
// the two pipeline stages are full.
module feedback_comb_echo_core import fce_pkg::*; #(
    parameter int MAX_DELAY = MAX_DELAY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fce_in_if.sink            i_smp,
    fce_out_if.source         o_smp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;

    fce_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fce_pipe #(
        .MAX_DELAY (MAX_DELAY)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_smp   (i_smp),
        .o_smp   (o_smp)
    );

endmodule
